/* src/rcr_pkg.sv */
// Shared types, codes and constants of the resource claim registry.
`timescale 1ns / 1ps
`default_nettype none
package rcr_pkg;

	localparam int PIN_COUNT_DEF       = 70;
	localparam int TIMER_COUNT_DEF     = 6;
	localparam int INTERRUPT_COUNT_DEF = 6;
	localparam int SERIAL_COUNT_DEF    = 4;
	localparam int SHARE_MAX_DEF       = 255;
	localparam int I2C_COUNT           = 1;
	localparam int SPI_COUNT           = 1;
	localparam int CNT_W               = 8;

	typedef enum logic [2:0] {
		REQ_CLAIM_EX   = 3'd0,
		REQ_CLAIM_SH   = 3'd1,
		REQ_RELEASE_EX = 3'd2,
		REQ_RELEASE_SH = 3'd3,
		REQ_QUERY      = 3'd4
	} req_e;

	typedef enum logic [2:0] {
		KIND_PIN    = 3'd0,
		KIND_TIMER  = 3'd1,
		KIND_IRQ    = 3'd2,
		KIND_I2C    = 3'd3,
		KIND_SPI    = 3'd4,
		KIND_SERIAL = 3'd5
	} kind_e;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_INVALID     = 3'd1,
		ST_UNSUPPORTED = 3'd2,
		ST_BUSY        = 3'd3,
		ST_CAPACITY    = 3'd4
	} status_e;

	typedef struct packed {
		logic valid;
		logic is_timer;
	} loc_t;

endpackage
`default_nettype wire

/* src/rcr_decode.sv */
// Maps a resource kind and index to its bit position in the claim map.
`timescale 1ns / 1ps
`default_nettype none
module rcr_decode #(
	parameter int PIN_COUNT       = rcr_pkg::PIN_COUNT_DEF,
	parameter int TIMER_COUNT     = rcr_pkg::TIMER_COUNT_DEF,
	parameter int INTERRUPT_COUNT = rcr_pkg::INTERRUPT_COUNT_DEF,
	parameter int SERIAL_COUNT    = rcr_pkg::SERIAL_COUNT_DEF,
	parameter int MAP_BITS        = PIN_COUNT + TIMER_COUNT + INTERRUPT_COUNT
	                                + rcr_pkg::I2C_COUNT + rcr_pkg::SPI_COUNT + SERIAL_COUNT,
	parameter int PW              = (MAP_BITS > 1) ? $clog2(MAP_BITS) : 1
) (
	input  wire logic [2:0]    res_kind,
	input  wire logic [7:0]    res_index,
	output rcr_pkg::loc_t      loc,
	output logic [PW-1:0]      pos
);
	import rcr_pkg::*;

	localparam int OFF_TIMER  = PIN_COUNT;
	localparam int OFF_IRQ    = OFF_TIMER + TIMER_COUNT;
	localparam int OFF_I2C    = OFF_IRQ + INTERRUPT_COUNT;
	localparam int OFF_SPI    = OFF_I2C + I2C_COUNT;
	localparam int OFF_SERIAL = OFF_SPI + SPI_COUNT;

	logic [8:0] count;
	logic [8:0] offset;
	logic [8:0] sum;

	always_comb begin
		case (res_kind)
			KIND_PIN: begin
				count  = 9'(PIN_COUNT);
				offset = 9'd0;
			end
			KIND_TIMER: begin
				count  = 9'(TIMER_COUNT);
				offset = 9'(OFF_TIMER);
			end
			KIND_IRQ: begin
				count  = 9'(INTERRUPT_COUNT);
				offset = 9'(OFF_IRQ);
			end
			KIND_I2C: begin
				count  = 9'(I2C_COUNT);
				offset = 9'(OFF_I2C);
			end
			KIND_SPI: begin
				count  = 9'(SPI_COUNT);
				offset = 9'(OFF_SPI);
			end
			KIND_SERIAL: begin
				count  = 9'(SERIAL_COUNT);
				offset = 9'(OFF_SERIAL);
			end
			default: begin
				count  = 9'd0;
				offset = 9'd0;
			end
		endcase
		sum          = {1'b0, res_index} + offset;
		loc.valid    = ({1'b0, res_index} < count);
		loc.is_timer = loc.valid && (res_kind == KIND_TIMER);
		pos          = sum[PW-1:0];
	end

endmodule
`default_nettype wire

/* src/rcr_table.sv */
// Claim map and timer share counters with the per-request update.
`timescale 1ns / 1ps
`default_nettype none
module rcr_table #(
	parameter int TIMER_COUNT = rcr_pkg::TIMER_COUNT_DEF,
	parameter int SHARE_MAX   = rcr_pkg::SHARE_MAX_DEF,
	parameter int MAP_BITS    = 88,
	parameter int PW          = (MAP_BITS > 1) ? $clog2(MAP_BITS) : 1,
	parameter int TW          = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic [2:0]    req_type,
	input  wire logic          handle_active,
	input  wire logic [TW-1:0] tidx,
	input  wire rcr_pkg::loc_t loc,
	input  wire logic [PW-1:0] pos,
	output logic [2:0]         status,
	output logic               held
);
	import rcr_pkg::*;

	logic [MAP_BITS-1:0] map_q;
	logic [CNT_W-1:0]    cnt_q [TIMER_COUNT];

	logic             bit_set;
	logic [CNT_W-1:0] cnt_cur;
	logic             cnt_nz;
	logic             set_bit;
	logic             clr_bit;
	logic             inc;
	logic             dec;

	always_comb begin
		bit_set = loc.valid && map_q[pos];
		cnt_cur = loc.is_timer ? cnt_q[tidx] : '0;
		cnt_nz  = (cnt_cur != '0);
		set_bit = 1'b0;
		clr_bit = 1'b0;
		inc     = 1'b0;
		dec     = 1'b0;
		status  = ST_OK;
		held    = 1'b0;
		case (req_type)
			REQ_CLAIM_EX: begin
				if (handle_active) status = ST_INVALID;
				else if (!loc.valid) status = ST_UNSUPPORTED;
				else if (bit_set || cnt_nz) status = ST_BUSY;
				else set_bit = 1'b1;
			end
			REQ_CLAIM_SH: begin
				if (handle_active) status = ST_INVALID;
				else if (!loc.is_timer) status = ST_UNSUPPORTED;
				else if (bit_set) status = ST_BUSY;
				else if (cnt_cur >= CNT_W'(SHARE_MAX)) status = ST_CAPACITY;
				else inc = 1'b1;
			end
			REQ_RELEASE_EX: begin
				clr_bit = loc.valid;
			end
			REQ_RELEASE_SH: begin
				dec = cnt_nz;
			end
			REQ_QUERY: begin
				held = bit_set || cnt_nz;
			end
			default: begin
				status = ST_UNSUPPORTED;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_q <= '0;
			for (int i = 0; i < TIMER_COUNT; i++) cnt_q[i] <= '0;
		end else if (en) begin
			if (set_bit) map_q[pos] <= 1'b1;
			if (clr_bit) map_q[pos] <= 1'b0;
			if (inc) cnt_q[tidx] <= cnt_cur + 1'b1;
			if (dec) cnt_q[tidx] <= cnt_cur - 1'b1;
		end
	end

endmodule
`default_nettype wire

/* src/resource_claim_registry_top.sv */
// Top level of the resource claim registry: request register, lookup, result register.
//
// Usage:
//   Request channel: drive req_type, res_kind, res_index and handle_active with
//   start high; the request is taken at a rising edge where start is high and
//   busy is low. busy stays low, so a request can be taken every cycle.
//   Result channel: done pulses for one cycle with status and held valid in
//   that cycle. The receiver cannot stall; each result shows exactly once.
//   Stages: a taken request goes into the request register; the map lookup and
//   update feed the result register, which drives done (two register stages:
//   request register, then result register).
//   Throughput: one request per cycle; the claim map and share counters are
//   updated at the same edge the result is registered, so the next request
//   already sees the new state.
//   Reset: arst_n low clears the claim map, all share counters and the
//   pending request and result strobes.
`timescale 1ns / 1ps
`default_nettype none
module resource_claim_registry_top #(
	parameter int PIN_COUNT       = rcr_pkg::PIN_COUNT_DEF,
	parameter int TIMER_COUNT     = rcr_pkg::TIMER_COUNT_DEF,
	parameter int INTERRUPT_COUNT = rcr_pkg::INTERRUPT_COUNT_DEF,
	parameter int SERIAL_COUNT    = rcr_pkg::SERIAL_COUNT_DEF,
	parameter int SHARE_MAX       = rcr_pkg::SHARE_MAX_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	output logic            busy,
	input  wire logic [2:0] req_type,
	input  wire logic [2:0] res_kind,
	input  wire logic [7:0] res_index,
	input  wire logic       handle_active,
	output logic            done,
	output logic [2:0]      status,
	output logic            held
);
	import rcr_pkg::*;

	localparam int MAP_BITS = PIN_COUNT + TIMER_COUNT + INTERRUPT_COUNT
	                          + I2C_COUNT + SPI_COUNT + SERIAL_COUNT;
	localparam int PW       = (MAP_BITS > 1) ? $clog2(MAP_BITS) : 1;
	localparam int TW       = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;

	logic       start_s1;
	logic [2:0] req_type_s1;
	logic [2:0] res_kind_s1;
	logic [7:0] res_index_s1;
	logic       handle_active_s1;

	loc_t          loc;
	logic [PW-1:0] pos;
	logic [2:0]    status_d;
	logic          held_d;

	logic       done_q;
	logic [2:0] status_q;
	logic       held_q;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_s1 <= 1'b0;
		end else begin
			start_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_type_s1      <= req_type;
			res_kind_s1      <= res_kind;
			res_index_s1     <= res_index;
			handle_active_s1 <= handle_active;
		end
	end

	rcr_decode #(
		.PIN_COUNT      (PIN_COUNT),
		.TIMER_COUNT    (TIMER_COUNT),
		.INTERRUPT_COUNT(INTERRUPT_COUNT),
		.SERIAL_COUNT   (SERIAL_COUNT),
		.MAP_BITS       (MAP_BITS),
		.PW             (PW)
	) u_decode (
		.res_kind (res_kind_s1),
		.res_index(res_index_s1),
		.loc      (loc),
		.pos      (pos)
	);

	rcr_table #(
		.TIMER_COUNT(TIMER_COUNT),
		.SHARE_MAX  (SHARE_MAX),
		.MAP_BITS   (MAP_BITS),
		.PW         (PW),
		.TW         (TW)
	) u_table (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (start_s1),
		.req_type     (req_type_s1),
		.handle_active(handle_active_s1),
		.tidx         (res_index_s1[TW-1:0]),
		.loc          (loc),
		.pos          (pos),
		.status       (status_d),
		.held         (held_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= start_s1;
		end
	end

	always_ff @(posedge clk) begin
		status_q <= status_d;
		held_q   <= held_d;
	end

	assign done   = done_q;
	assign status = status_q;
	assign held   = done_q && held_q;

endmodule
`default_nettype wire

/* src/rcr_checker.sv */
// Port-level checks of the resource claim registry and their binding.
`timescale 1ns / 1ps
`default_nettype none
module rcr_props (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       start,
	input wire logic       busy,
	input wire logic       done,
	input wire logic [2:0] status,
	input wire logic       held
);
	import rcr_pkg::*;

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##2 done)
		else $error("request without result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 2))
		else $error("result without request");

	a_held_ok: assert property (@(posedge clk) disable iff (!arst_n)
		held |-> done && status == ST_OK)
		else $error("held outside an ok result");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status == ST_OK || status == ST_INVALID || status == ST_UNSUPPORTED
		          || status == ST_BUSY || status == ST_CAPACITY))
		else $error("undefined status code");

endmodule

bind resource_claim_registry_top rcr_props u_rcr_props (.*);
`default_nettype wire

/* sim/rcr_checker.sv */
// Checker for the resource claim registry: predicts each request's answer and compares results.
`timescale 1ns / 1ps
module rcr_checker #(
	parameter int PIN_COUNT       = rcr_pkg::PIN_COUNT_DEF,
	parameter int TIMER_COUNT     = rcr_pkg::TIMER_COUNT_DEF,
	parameter int INTERRUPT_COUNT = rcr_pkg::INTERRUPT_COUNT_DEF,
	parameter int SERIAL_COUNT    = rcr_pkg::SERIAL_COUNT_DEF,
	parameter int SHARE_MAX       = rcr_pkg::SHARE_MAX_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire logic       busy,
	input  wire logic [2:0] req_type,
	input  wire logic [2:0] res_kind,
	input  wire logic [7:0] res_index,
	input  wire logic       handle_active,
	input  wire logic       done,
	input  wire logic [2:0] status,
	input  wire logic       held,
	output int              errors,
	output int              pending
);
	import rcr_pkg::*;

	localparam int MAP_BITS = PIN_COUNT + TIMER_COUNT + INTERRUPT_COUNT + I2C_COUNT
		+ SPI_COUNT + SERIAL_COUNT;

	typedef struct packed {
		status_e st;
		logic    held;
	} answer_t;

	logic             claim_bits [MAP_BITS];
	logic [CNT_W-1:0] share_cnt [TIMER_COUNT];
	answer_t          answers_due [$];
	answer_t          want;
	int               err_cnt = 0;
	int               due_cnt = 0;

	assign errors  = err_cnt;
	assign pending = due_cnt;

	function automatic bit find_slot(input logic [2:0] kind, input logic [7:0] idx,
		output int slot);
		int base;
		int cnt;
		base = 0;
		cnt  = 0;
		slot = 0;
		case (kind)
			KIND_PIN: begin
				base = 0;
				cnt  = PIN_COUNT;
			end
			KIND_TIMER: begin
				base = PIN_COUNT;
				cnt  = TIMER_COUNT;
			end
			KIND_IRQ: begin
				base = PIN_COUNT + TIMER_COUNT;
				cnt  = INTERRUPT_COUNT;
			end
			KIND_I2C: begin
				base = PIN_COUNT + TIMER_COUNT + INTERRUPT_COUNT;
				cnt  = I2C_COUNT;
			end
			KIND_SPI: begin
				base = PIN_COUNT + TIMER_COUNT + INTERRUPT_COUNT + I2C_COUNT;
				cnt  = SPI_COUNT;
			end
			KIND_SERIAL: begin
				base = PIN_COUNT + TIMER_COUNT + INTERRUPT_COUNT + I2C_COUNT + SPI_COUNT;
				cnt  = SERIAL_COUNT;
			end
			default: return 1'b0;
		endcase
		if (int'(idx) >= cnt)
			return 1'b0;
		slot = base + int'(idx);
		return 1'b1;
	endfunction

	function automatic answer_t serve_request(input logic [2:0] rq, input logic [2:0] kind,
		input logic [7:0] idx, input logic act);
		int      slot;
		bit      in_map;
		bit      timer;
		answer_t a;
		a.st   = ST_OK;
		a.held = 1'b0;
		in_map = find_slot(kind, idx, slot);
		timer  = in_map && kind == KIND_TIMER;
		case (rq)
			REQ_CLAIM_EX: begin
				if (act)
					a.st = ST_INVALID;
				else if (!in_map)
					a.st = ST_UNSUPPORTED;
				else if (claim_bits[slot])
					a.st = ST_BUSY;
				else if (timer && share_cnt[idx] != 0)
					a.st = ST_BUSY;
				else
					claim_bits[slot] = 1'b1;
			end
			REQ_CLAIM_SH: begin
				if (act)
					a.st = ST_INVALID;
				else if (!timer)
					a.st = ST_UNSUPPORTED;
				else if (claim_bits[slot])
					a.st = ST_BUSY;
				else if (int'(share_cnt[idx]) >= SHARE_MAX)
					a.st = ST_CAPACITY;
				else
					share_cnt[idx] = share_cnt[idx] + 1'b1;
			end
			REQ_RELEASE_EX: begin
				if (in_map)
					claim_bits[slot] = 1'b0;
			end
			REQ_RELEASE_SH: begin
				if (timer && share_cnt[idx] != 0)
					share_cnt[idx] = share_cnt[idx] - 1'b1;
			end
			REQ_QUERY: begin
				if (in_map && (claim_bits[slot] || (timer && share_cnt[idx] != 0)))
					a.held = 1'b1;
			end
			default: a.st = ST_UNSUPPORTED;
		endcase
		return a;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAP_BITS; i++)
				claim_bits[i] = 1'b0;
			for (int i = 0; i < TIMER_COUNT; i++)
				share_cnt[i] = '0;
			answers_due.delete();
			due_cnt = 0;
		end else begin
			if (done) begin
				if (answers_due.size() == 0) begin
					$display("%0t: result with no request outstanding: status %0d held %0d",
						$time, status, held);
					err_cnt++;
				end else begin
					want = answers_due.pop_front();
					if (status !== want.st) begin
						$display("%0t: status mismatch: expected %0d, actual %0d",
							$time, want.st, status);
						err_cnt++;
					end
					if (held !== want.held) begin
						$display("%0t: held mismatch: expected %0d, actual %0d",
							$time, want.held, held);
						err_cnt++;
					end
				end
			end
			if (start && !busy)
				answers_due.push_back(serve_request(req_type, res_kind, res_index,
					handle_active));
			due_cnt = answers_due.size();
		end
	end

endmodule

/* sim/tb.sv */
// Testbench top of the resource claim registry: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps
module tb;
	import rcr_pkg::*;

	localparam logic [2:0] REQ_RSVD_FIRST  = 3'd5;
	localparam logic [2:0] REQ_RSVD_LAST   = 3'd7;
	localparam logic [2:0] KIND_RSVD_FIRST = 3'd6;
	localparam logic [2:0] KIND_RSVD_LAST  = 3'd7;
	localparam int         IDLE_LIMIT      = 1000;
	localparam int         TARGET_ITEMS    = 1950;

	logic       clk           = 1'b0;
	logic       arst_n        = 1'b0;
	logic       start         = 1'b0;
	logic [2:0] req_type      = '0;
	logic [2:0] res_kind      = '0;
	logic [7:0] res_index     = '0;
	logic       handle_active = 1'b0;
	logic       busy;
	logic       done;
	logic [2:0] status;
	logic       held;
	int         errors;
	int         pending;
	int         sent  = 0;
	int         quiet = 0;
	bit         calm  = 1'b0;
	bit         paused_mid = 1'b0;

	always #5 clk = ~clk;

	resource_claim_registry_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.req_type     (req_type),
		.res_kind     (res_kind),
		.res_index    (res_index),
		.handle_active(handle_active),
		.done         (done),
		.status       (status),
		.held         (held)
	);

	rcr_checker u_chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.req_type     (req_type),
		.res_kind     (res_kind),
		.res_index    (res_index),
		.handle_active(handle_active),
		.done         (done),
		.status       (status),
		.held         (held),
		.errors       (errors),
		.pending      (pending)
	);

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				quiet <= 0;
			else
				quiet <= quiet + 1;
			if (quiet >= IDLE_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	function automatic int kind_size(input logic [2:0] kind);
		case (kind)
			KIND_PIN:    return PIN_COUNT_DEF;
			KIND_TIMER:  return TIMER_COUNT_DEF;
			KIND_IRQ:    return INTERRUPT_COUNT_DEF;
			KIND_I2C:    return I2C_COUNT;
			KIND_SPI:    return SPI_COUNT;
			KIND_SERIAL: return SERIAL_COUNT_DEF;
			default:     return 0;
		endcase
	endfunction

	task automatic put(input logic [2:0] rq, input logic [2:0] kind, input logic [7:0] idx,
		input logic act);
		while (!calm && $urandom_range(0, 99) < 28) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start         <= 1'b1;
		req_type      <= rq;
		res_kind      <= kind;
		res_index     <= idx;
		handle_active <= act;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sent++;
	endtask

	// hold off until every outstanding request has answered
	task automatic settle();
		start <= 1'b0;
		do
			@(negedge clk);
		while (pending != 0);
		@(posedge clk);
	endtask

	task automatic exclusive_life();
		logic [2:0] k;
		logic [7:0] i;
		k = 3'($urandom_range(int'(KIND_SERIAL), int'(KIND_PIN)));
		i = 8'($urandom_range(kind_size(k) - 1, 0));
		put(REQ_CLAIM_EX, k, i, 1'b0);
		put(REQ_QUERY, k, i, 1'($urandom));
		if ($urandom_range(0, 1))
			put(REQ_CLAIM_EX, k, i, 1'($urandom_range(0, 3) == 0));
		if ($urandom_range(0, 3) == 0)
			put(REQ_CLAIM_SH, k, i, 1'b0);
		if ($urandom_range(0, 3) != 0) begin
			put(REQ_RELEASE_EX, k, i, 1'($urandom));
			put(REQ_QUERY, k, i, 1'($urandom));
		end
	endtask

	task automatic shared_life();
		logic [7:0] t;
		int         n;
		t = 8'($urandom_range(TIMER_COUNT_DEF - 1, 0));
		n = $urandom_range(1, 4);
		repeat (n)
			put(REQ_CLAIM_SH, KIND_TIMER, t, 1'b0);
		put(REQ_QUERY, KIND_TIMER, t, 1'($urandom));
		put(REQ_CLAIM_EX, KIND_TIMER, t, 1'b0);
		repeat ($urandom_range(n + 1, n - 1))
			put(REQ_RELEASE_SH, KIND_TIMER, t, 1'($urandom));
		put(REQ_QUERY, KIND_TIMER, t, 1'b0);
	endtask

	task automatic noise();
		logic [2:0] k;
		if ($urandom_range(0, 1)) begin
			put(3'($urandom_range(int'(REQ_RSVD_LAST), int'(REQ_CLAIM_EX))),
				3'($urandom_range(int'(KIND_RSVD_LAST), int'(KIND_PIN))),
				8'($urandom_range(255, 0)), 1'($urandom));
		end else begin
			k = 3'($urandom_range(int'(KIND_SERIAL), int'(KIND_PIN)));
			put(3'($urandom_range(int'(REQ_QUERY), int'(REQ_CLAIM_EX))), k,
				8'($urandom_range(kind_size(k), 0)), 1'($urandom_range(0, 4) == 0));
		end
	endtask

	initial begin
		logic [7:0] t;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		put(REQ_QUERY, KIND_PIN, 8'd0, 1'b1);
		put(REQ_CLAIM_EX, KIND_PIN, 8'd0, 1'b0);
		put(REQ_QUERY, KIND_PIN, 8'd0, 1'b0);
		put(REQ_CLAIM_EX, KIND_PIN, 8'd0, 1'b0);
		put(REQ_CLAIM_EX, KIND_PIN, 8'(PIN_COUNT_DEF - 1), 1'b1);
		put(REQ_CLAIM_EX, KIND_PIN, 8'(PIN_COUNT_DEF), 1'b0);
		put(REQ_CLAIM_EX, KIND_RSVD_LAST, 8'd0, 1'b0);
		put(REQ_CLAIM_SH, KIND_PIN, 8'd0, 1'b0);
		put(REQ_CLAIM_SH, KIND_TIMER, 8'(TIMER_COUNT_DEF - 1), 1'b0);
		put(REQ_CLAIM_EX, KIND_TIMER, 8'(TIMER_COUNT_DEF - 1), 1'b0);
		put(REQ_QUERY, KIND_TIMER, 8'(TIMER_COUNT_DEF - 1), 1'b0);
		put(REQ_RELEASE_SH, KIND_TIMER, 8'(TIMER_COUNT_DEF - 1), 1'b1);
		put(REQ_CLAIM_EX, KIND_TIMER, 8'(TIMER_COUNT_DEF - 1), 1'b0);
		put(REQ_CLAIM_SH, KIND_TIMER, 8'(TIMER_COUNT_DEF - 1), 1'b0);
		put(REQ_RELEASE_EX, KIND_TIMER, 8'(TIMER_COUNT_DEF - 1), 1'b0);
		put(REQ_CLAIM_SH, KIND_TIMER, 8'(TIMER_COUNT_DEF), 1'b0);
		put(REQ_CLAIM_SH, KIND_TIMER, 8'd0, 1'b1);
		put(REQ_RSVD_LAST, KIND_RSVD_FIRST, 8'd255, 1'b1);
		put(REQ_RSVD_FIRST, KIND_PIN, 8'd0, 1'b0);
		put(REQ_RELEASE_EX, KIND_PIN, 8'd0, 1'b0);
		put(REQ_RELEASE_EX, KIND_PIN, 8'd200, 1'b0);
		put(REQ_RELEASE_SH, KIND_TIMER, 8'd0, 1'b0);
		put(REQ_CLAIM_EX, KIND_SERIAL, 8'(SERIAL_COUNT_DEF - 1), 1'b0);
		put(REQ_CLAIM_EX, KIND_IRQ, 8'(INTERRUPT_COUNT_DEF - 1), 1'b0);
		put(REQ_QUERY, KIND_SERIAL, 8'(SERIAL_COUNT_DEF), 1'b0);
		settle();

		// fill one timer's share count to its limit and claim once more, then drain it
		t = 8'($urandom_range(TIMER_COUNT_DEF - 1, 0));
		repeat (SHARE_MAX_DEF + 1)
			put(REQ_CLAIM_SH, KIND_TIMER, t, 1'b0);
		put(REQ_QUERY, KIND_TIMER, t, 1'b0);
		put(REQ_CLAIM_EX, KIND_TIMER, t, 1'b0);
		repeat (SHARE_MAX_DEF + 1)
			put(REQ_RELEASE_SH, KIND_TIMER, t, 1'($urandom));
		put(REQ_QUERY, KIND_TIMER, t, 1'b0);

		while (sent < TARGET_ITEMS) begin
			calm = sent >= 1100 && sent < 1400;
			if (sent >= 1500 && !paused_mid) begin
				paused_mid = 1'b1;
				settle();
			end
			case ($urandom_range(0, 9))
				0, 1, 2: exclusive_life();
				3, 4:    shared_life();
				default: noise();
			endcase
		end

		settle();
		repeat (6) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

/* sim.f */
src/rcr_pkg.sv
src/rcr_decode.sv
src/rcr_table.sv
src/resource_claim_registry_top.sv
src/rcr_checker.sv
sim/rcr_checker.sv
sim/tb.sv
